// File: sv/contiguous_page_run_allocator_defines.svh
// ---------------------------------------------------------------------------
// contiguous_page_run_allocator_defines
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_PAGE_RUN_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_PAGE_RUN_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CPRA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CPRA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cpra_pkg.sv
// ---------------------------------------------------------------------------
// cpra_pkg
// shared constants, codes and control types of the page run allocator
// ---------------------------------------------------------------------------
package cpra_pkg;

    // sizes
    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = $clog2(NUM_PAGES);
    localparam int ROVER_W   = PAGE_W + 1;

    // transaction field widths
    localparam int OP_W     = 1;
    localparam int RUN_W    = 13;
    localparam int IDX_W    = 12;
    localparam int STATUS_W = 2;
    localparam int FIRST_W  = 12;

    // configuration port
    localparam int POOL_W = 13;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(4096);
    localparam logic [APB_AW-3:0] REG_POOL_PAGES = '0;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 1'b0;
    localparam logic [OP_W-1:0] OP_RELEASE = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_OOM   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // operand select of the shared rover adder
    typedef enum logic [1:0] {
        ADD_COUNT = 2'd0,
        ADD_STEP  = 2'd1,
        ADD_IDX   = 2'd2
    } t_add_sel;

    // sequencer to scan unit
    typedef struct packed {
        logic     start;
        logic     addr_load;
        logic     cnt_inc;
        logic     advance;
        logic     idx_inc;
        logic     commit;
        t_add_sel add_sel;
    } t_scan_ctl;

    // scan unit to sequencer
    typedef struct packed {
        logic              rover_oob;
        logic              page_free;
        logic              run_done;
        logic              mark_last;
        logic [PAGE_W-1:0] first;
    } t_scan_sts;

endpackage

// File: sv/cpra_ifs.sv
// ---------------------------------------------------------------------------
// cpra_ifs
// request and response channels with valid/ready handshake
// ---------------------------------------------------------------------------

// request channel: allocate a run or release one page
interface cpra_req_if;
    logic                          valid;
    logic                          ready;
    logic [cpra_pkg::OP_W-1:0]     op;
    logic [cpra_pkg::RUN_W-1:0]    run_length;
    logic [cpra_pkg::IDX_W-1:0]    page_index;

    modport source (output valid, op, run_length, page_index, input ready);
    modport sink   (input valid, op, run_length, page_index, output ready);
endinterface

// response channel: one per request
interface cpra_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cpra_pkg::STATUS_W-1:0] status;
    logic [cpra_pkg::FIRST_W-1:0]  run_start;

    modport source (output valid, status, run_start, input ready);
    modport sink   (input valid, status, run_start, output ready);
endinterface

// File: sv/cpra_ram.sv
// ---------------------------------------------------------------------------
// cpra_ram
// generic single-write, single-read memory with registered read data
// ---------------------------------------------------------------------------
module cpra_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/cpra_scan.sv
// ---------------------------------------------------------------------------
// cpra_scan
// rover, run counter and mark index around one shared adder
// ---------------------------------------------------------------------------
module cpra_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cpra_pkg::t_scan_ctl           i_ctl,
    input  logic [cpra_pkg::RUN_W-1:0]    i_want,
    input  logic [cpra_pkg::ROVER_W-1:0]  i_limit,
    input  logic                          i_rd_used,
    output logic [cpra_pkg::ROVER_W-1:0]  o_addr,
    output cpra_pkg::t_scan_sts           o_sts
);

    logic [cpra_pkg::ROVER_W-1:0] r_rover, n_rover;
    logic [cpra_pkg::ROVER_W-1:0] r_count, n_count;
    logic [cpra_pkg::ROVER_W-1:0] r_idx, n_idx;
    logic [cpra_pkg::ROVER_W-1:0] r_addr, n_addr;
    logic [cpra_pkg::RUN_W-1:0]   r_want, n_want;
    logic [cpra_pkg::ROVER_W-1:0] w_opnd;
    logic [cpra_pkg::ROVER_W-1:0] w_sum;

    // operand select of the shared adder
    always_comb begin
        case (i_ctl.add_sel)
            cpra_pkg::ADD_COUNT: w_opnd = r_count;
            cpra_pkg::ADD_STEP:  w_opnd = (r_count == '0) ? cpra_pkg::ROVER_W'(1) : r_count;
            cpra_pkg::ADD_IDX:   w_opnd = r_idx;
            default:             w_opnd = r_count;
        endcase
    end

    // rover plus operand: page address, rover advance or run commit
    assign w_sum  = r_rover + w_opnd;
    assign o_addr = w_sum;

    // next state of the scan registers
    always_comb begin
        n_rover = r_rover;
        n_count = r_count;
        n_idx   = r_idx;
        n_addr  = r_addr;
        n_want  = r_want;
        if (i_ctl.start) begin
            n_count = '0;
            n_idx   = '0;
            n_want  = i_want;
        end
        if (i_ctl.addr_load) begin
            n_addr = w_sum;
        end
        if (i_ctl.cnt_inc) begin
            n_count = r_count + cpra_pkg::ROVER_W'(1);
        end
        if (i_ctl.advance) begin
            n_rover = w_sum;
            n_count = '0;
        end
        if (i_ctl.idx_inc) begin
            n_idx = r_idx + cpra_pkg::ROVER_W'(1);
        end
        if (i_ctl.commit) begin
            n_rover = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_rover <= n_rover;
            r_count <= n_count;
            r_idx   <= n_idx;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_want <= n_want;
    end

    // status back to the sequencer
    always_comb begin
        o_sts.rover_oob = (r_rover >= i_limit);
        o_sts.page_free = !i_rd_used && (r_addr < i_limit);
        o_sts.run_done  = ((32'(r_count) + 32'd1) == 32'(r_want));
        o_sts.mark_last = ((32'(r_idx) + 32'd1) == 32'(r_count));
        o_sts.first     = r_rover[cpra_pkg::PAGE_W-1:0];
    end

endmodule

// File: sv/contiguous_page_run_allocator.sv
// ---------------------------------------------------------------------------
// contiguous_page_run_allocator
// bitmap page allocator with next-fit rover over a one-bit-per-page map
// ---------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  i_req     in    valid/ready        op, run_length, page_index
//  o_rsp     out   valid/ready        status, run_start
//  apb       in    psel/penable       pool_pages at byte address 0
//
//  after reset the map is set to all used, one page a cycle, with i_req.ready
//  low; configuration writes are taken meanwhile; release and zero run length:
//  S_IDLE, then S_DONE; allocate: S_READ and S_CHECK per page checked, as the
//  map memory has a single registered read port, then S_MARK per page marked,
//  S_FIN and S_DONE; out of memory ends from S_CHECK in S_DONE
//  a stalled o_rsp holds one result; the next request is taken meanwhile
// ---------------------------------------------------------------------------
module contiguous_page_run_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    cpra_req_if.sink                     i_req,
    cpra_rsp_if.source                   o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [cpra_pkg::APB_AW-1:0]  paddr,
    input  logic [cpra_pkg::APB_DW-1:0]  pwdata,
    output logic [cpra_pkg::APB_DW-1:0]  prdata,
    output logic                         pready
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_CHECK = 7'b0001000,
        S_MARK  = 7'b0010000,
        S_FIN   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    logic [cpra_pkg::PAGE_W-1:0]     r_clr, n_clr;
    logic [cpra_pkg::POOL_W-1:0]     r_pool;
    cpra_pkg::t_status               r_res_status, n_res_status;
    logic [cpra_pkg::FIRST_W-1:0]    r_res_first, n_res_first;
    logic                            r_out_valid, n_out_valid;
    cpra_pkg::t_status               r_out_status, n_out_status;
    logic [cpra_pkg::FIRST_W-1:0]    r_out_first, n_out_first;

    logic [cpra_pkg::ROVER_W-1:0]    w_limit;
    logic                            w_accept;
    logic                            w_idx_ok;
    logic                            w_reg_sel;
    logic                            w_cfg_wr;
    cpra_pkg::t_scan_ctl             w_ctl;
    cpra_pkg::t_scan_sts             w_sts;
    logic [cpra_pkg::ROVER_W-1:0]    w_addr;
    logic                            w_ram_we;
    logic [cpra_pkg::PAGE_W-1:0]     w_ram_waddr;
    logic                            w_ram_wdata;
    logic                            w_rd_used;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_sel = (paddr[cpra_pkg::APB_AW-1:2] == cpra_pkg::REG_POOL_PAGES);
    assign w_cfg_wr  = psel && penable && pwrite && w_reg_sel;
    assign prdata    = w_reg_sel ? cpra_pkg::APB_DW'(r_pool) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool <= cpra_pkg::POOL_RESET;
        end else if (w_cfg_wr) begin
            r_pool <= pwdata[cpra_pkg::POOL_W-1:0];
        end
    end

    // effective pool is the smaller of the register and the map size
    assign w_limit = (32'(r_pool) >= cpra_pkg::NUM_PAGES) ?
                     cpra_pkg::ROVER_W'(cpra_pkg::NUM_PAGES) : cpra_pkg::ROVER_W'(r_pool);

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_idx_ok    = (32'(i_req.page_index) < 32'(w_limit));

    // used map
    cpra_ram #(
        .WIDTH (1),
        .DEPTH (cpra_pkg::NUM_PAGES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_addr[cpra_pkg::PAGE_W-1:0]),
        .o_rdata (w_rd_used)
    );

    // rover and run search datapath
    cpra_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_want    (i_req.run_length),
        .i_limit   (w_limit),
        .i_rd_used (w_rd_used),
        .o_addr    (w_addr),
        .o_sts     (w_sts)
    );

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_res_status = r_res_status;
        n_res_first  = r_res_first;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_first  = r_out_first;
        w_ctl        = '0;
        w_ctl.add_sel = cpra_pkg::ADD_COUNT;
        w_ram_we     = 1'b0;
        w_ram_waddr  = r_clr;
        w_ram_wdata  = 1'b1;
        case (r_state)
            // mark every page used after reset
            S_CLEAR: begin
                w_ram_we = 1'b1;
                n_clr    = r_clr + cpra_pkg::PAGE_W'(1);
                if (r_clr == cpra_pkg::PAGE_W'(cpra_pkg::NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // take a request
            S_IDLE: begin
                if (w_accept) begin
                    n_res_first = '0;
                    if (i_req.op == cpra_pkg::OP_RELEASE) begin
                        w_ram_waddr = i_req.page_index[cpra_pkg::PAGE_W-1:0];
                        w_ram_wdata = 1'b0;
                        w_ram_we    = w_idx_ok;
                        n_res_status = w_idx_ok ? cpra_pkg::ST_OK : cpra_pkg::ST_RANGE;
                        n_state     = S_DONE;
                    end else if (i_req.run_length == '0) begin
                        n_res_status = cpra_pkg::ST_OK;
                        n_state     = S_DONE;
                    end else begin
                        w_ctl.start = 1'b1;
                        n_state     = S_READ;
                    end
                end
            end
            // read page at rover plus count
            S_READ: begin
                w_ctl.addr_load = 1'b1;
                n_state         = S_CHECK;
            end
            // decide on the page just read
            S_CHECK: begin
                if (w_sts.rover_oob) begin
                    n_res_status = cpra_pkg::ST_OOM;
                    n_res_first  = '0;
                    n_state      = S_DONE;
                end else if (w_sts.page_free) begin
                    w_ctl.cnt_inc = 1'b1;
                    n_state       = w_sts.run_done ? S_MARK : S_READ;
                end else begin
                    w_ctl.add_sel = cpra_pkg::ADD_STEP;
                    w_ctl.advance = 1'b1;
                    n_state       = S_READ;
                end
            end
            // mark the run's pages used, one a cycle
            S_MARK: begin
                w_ctl.add_sel = cpra_pkg::ADD_IDX;
                w_ram_we      = 1'b1;
                w_ram_waddr   = w_addr[cpra_pkg::PAGE_W-1:0];
                w_ram_wdata   = 1'b1;
                if (w_sts.mark_last) begin
                    n_state = S_FIN;
                end else begin
                    w_ctl.idx_inc = 1'b1;
                end
            end
            // move the rover past the run
            S_FIN: begin
                w_ctl.commit = 1'b1;
                n_res_status = cpra_pkg::ST_OK;
                n_res_first  = cpra_pkg::FIRST_W'(w_sts.first);
                n_state      = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_first  = r_res_first;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload registers
    always_ff @(posedge i_clk) begin
        r_res_status <= n_res_status;
        r_res_first  <= n_res_first;
        r_out_status <= n_out_status;
        r_out_first  <= n_out_first;
    end

    // response channel
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.run_start = r_out_first;

endmodule

// File: sv/cpra_checker.sv
// ---------------------------------------------------------------------------
// cpra_checker
// port-level checks of the page run allocator, bound to the top level
// ---------------------------------------------------------------------------
`include "contiguous_page_run_allocator_defines.svh"

module cpra_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_req_valid,
    input logic                          i_req_ready,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [cpra_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [cpra_pkg::FIRST_W-1:0]  i_rsp_first
);

    // a stalled response holds its payload
    `CPRA_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_first), "response changed while stalled")

    // only defined status codes reach the port
    `CPRA_ASSERT_NOW(a_status_code, i_rsp_valid, i_rsp_status == cpra_pkg::ST_OK || i_rsp_status == cpra_pkg::ST_OOM || i_rsp_status == cpra_pkg::ST_RANGE, "undefined status code")

    // failed or rejected transactions return page zero
    `CPRA_ASSERT_NOW(a_fail_first_zero, i_rsp_valid && i_rsp_status != cpra_pkg::ST_OK, i_rsp_first == '0, "nonzero first page on failure")

    // one request at a time: ready drops after each accepted transaction
    `CPRA_ASSERT_NEXT(a_one_in_flight, i_req_valid && i_req_ready, !i_req_ready, "request taken while busy")

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_first  (o_rsp.run_start)
);

// File: verif/contiguous_page_run_allocator_test.sv
// ---------------------------------------------------------------------------
// contiguous_page_run_allocator_test
// self-checking bench: frees pages and asks for page runs under a series of
// pool sizes, predicts every response from a bit-level copy of the used map
// and the rover, and compares each response field by field
// ---------------------------------------------------------------------------

// used-map and rover predictor with the queue of responses still due
class page_alloc_scoreboard;
    typedef struct {
        cpra_pkg::t_status            status;
        logic [cpra_pkg::FIRST_W-1:0] run_start;
    } t_grant;

    bit   [cpra_pkg::NUM_PAGES-1:0] page_used;
    logic [cpra_pkg::ROVER_W-1:0]   rover;
    logic [cpra_pkg::POOL_W-1:0]    pool_pages;
    t_grant                         grants_due[$];
    int unsigned                    n_requests;
    int unsigned                    n_failures;

    function new();
        page_used  = '1;
        rover      = '0;
        pool_pages = cpra_pkg::POOL_RESET;
        n_requests = 0;
        n_failures = 0;
    endfunction

    function int unsigned pool_limit();
        return (pool_pages > cpra_pkg::NUM_PAGES) ? cpra_pkg::NUM_PAGES : pool_pages;
    endfunction

    // pages at or past the pool always read as used
    function bit page_taken(int unsigned page);
        return (page >= pool_limit()) ? 1'b1 : page_used[page];
    endfunction

    function int unsigned pending();
        return grants_due.size();
    endfunction

    function void report(string msg);
        n_failures++;
        if (n_failures <= 10)
            $display("mismatch: %0s", msg);
    endfunction

    // work out the response of one request transaction and queue it
    function void note_request(logic [cpra_pkg::OP_W-1:0] op,
                               logic [cpra_pkg::RUN_W-1:0] run_length,
                               logic [cpra_pkg::IDX_W-1:0] page_index);
        int unsigned limit;
        int unsigned scan;
        int unsigned count;
        int unsigned p;
        bit          done;
        t_grant      g;
        limit       = pool_limit();
        scan        = rover;
        count       = 0;
        done        = 1'b0;
        g.status    = cpra_pkg::ST_OK;
        g.run_start = '0;
        if (op == cpra_pkg::OP_RELEASE) begin
            if (page_index >= limit)
                g.status = cpra_pkg::ST_RANGE;
            else
                page_used[page_index] = 1'b0;
        end else if (run_length != 0) begin
            // next-fit scan from the rover
            while (!done) begin
                if (scan >= limit) begin
                    g.status = cpra_pkg::ST_OOM;
                    done     = 1'b1;
                end else if (!page_taken(scan + count)) begin
                    count++;
                    if (count == run_length) begin
                        for (p = scan; p < scan + count; p++)
                            page_used[p] = 1'b1;
                        g.run_start = cpra_pkg::FIRST_W'(scan);
                        scan += count;
                        done = 1'b1;
                    end
                end else begin
                    scan += (count == 0) ? 1 : count;
                    count = 0;
                end
            end
            rover = cpra_pkg::ROVER_W'(scan);
        end
        grants_due.push_back(g);
        n_requests++;
    endfunction

    // compare one response transaction with the oldest one due
    function void check_response(logic [cpra_pkg::STATUS_W-1:0] status,
                                 logic [cpra_pkg::FIRST_W-1:0] run_start);
        t_grant g;
        if (grants_due.size() == 0) begin
            report($sformatf("response with none due: status %0d run_start %0d",
                             status, run_start));
            return;
        end
        g = grants_due.pop_front();
        if (status !== g.status)
            report($sformatf("status expected %0d, got %0d", g.status, status));
        if (run_start !== g.run_start)
            report($sformatf("run_start expected %0d, got %0d", g.run_start, run_start));
    endfunction
endclass

module contiguous_page_run_allocator_test;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 7;
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int DRAIN_CYCLES   = 64;
    localparam int HOLD_AT        = 1150;
    localparam int HOLD_CYCLES    = 400;
    localparam int PHASE_ITEMS    = 138;
    localparam int N_PHASES       = 10;
    localparam int unsigned PHASE_POOLS [N_PHASES] =
        '{180, 450, 800, 1200, 1650, 2150, 2700, 3300, 8191, 4096};

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [cpra_pkg::APB_AW-1:0] paddr;
    logic [cpra_pkg::APB_DW-1:0] pwdata;
    logic [cpra_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    cpra_req_if req_ch ();
    cpra_rsp_if rsp_ch ();

    page_alloc_scoreboard sb;
    int unsigned          hold_left;
    bit                   hold_done;
    int unsigned          quiet_cycles;

    contiguous_page_run_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    // idle mix: sender light then heavy, then no idling at all
    function int unsigned idle_phase();
        if (sb.n_requests < 470)
            return 0;
        else if (sb.n_requests < 940)
            return 1;
        return 2;
    endfunction

    function int unsigned tx_idle_pct();
        case (idle_phase())
            0:       return 34;
            1:       return 53;
            default: return 0;
        endcase
    endfunction

    function int unsigned rx_idle_pct();
        case (idle_phase())
            0:       return 53;
            1:       return 34;
            default: return 0;
        endcase
    endfunction

    // offer one request transaction and note it once accepted
    task automatic send_req(logic [cpra_pkg::OP_W-1:0] op,
                            logic [cpra_pkg::RUN_W-1:0] run_length,
                            logic [cpra_pkg::IDX_W-1:0] page_index);
        while ($urandom_range(99) < tx_idle_pct()) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.run_length <= run_length;
        req_ch.page_index <= page_index;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sb.note_request(op, run_length, page_index);
    endtask

    task automatic alloc_run(logic [cpra_pkg::RUN_W-1:0] run_length);
        send_req(cpra_pkg::OP_ALLOC, run_length, cpra_pkg::IDX_W'($urandom));
    endtask

    task automatic free_page(logic [cpra_pkg::IDX_W-1:0] page_index);
        send_req(cpra_pkg::OP_RELEASE, cpra_pkg::RUN_W'($urandom), page_index);
    endtask

    // one apb transfer to the pool register: setup then access
    task automatic apb_access(bit wr, logic [cpra_pkg::POOL_W-1:0] wdata,
                              output logic [cpra_pkg::APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {cpra_pkg::REG_POOL_PAGES, 2'b00};
        pwdata  <= cpra_pkg::APB_DW'(wdata);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_pool(logic [cpra_pkg::POOL_W-1:0] value);
        logic [cpra_pkg::APB_DW-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd !== cpra_pkg::APB_DW'(value))
            sb.report($sformatf("pool_pages readback expected %0d, got %0d", value, rd));
    endtask

    // change the pool only with nothing in flight
    task automatic set_pool(logic [cpra_pkg::POOL_W-1:0] value);
        logic [cpra_pkg::APB_DW-1:0] rd;
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        apb_access(1'b1, value, rd);
        sb.pool_pages = value;
        check_pool(value);
    endtask

    // mostly frees just ahead of the rover and short runs, some noise,
    // closed by a long run of 600 to 8191 pages and then a one-page run
    task automatic run_phase(logic [cpra_pkg::POOL_W-1:0] pool);
        int unsigned limit;
        int unsigned r;
        int unsigned pick;
        int unsigned k;
        int unsigned top;
        logic [cpra_pkg::RUN_W-1:0] len;
        set_pool(pool);
        limit = sb.pool_limit();
        for (k = 0; k < PHASE_ITEMS - 2; k++) begin
            r    = sb.rover;
            pick = $urandom_range(99);
            if (pick < 45 && r < limit) begin
                top = (r + 24 < limit) ? r + 24 : limit - 1;
                free_page(cpra_pkg::IDX_W'($urandom_range(top, r)));
            end else if (pick < 78) begin
                if ($urandom_range(5) == 0)
                    len = cpra_pkg::RUN_W'($urandom_range(16, 5));
                else
                    len = cpra_pkg::RUN_W'($urandom_range(4, 1));
                alloc_run(len);
            end else if (pick < 83) begin
                alloc_run('0);
            end else begin
                free_page(cpra_pkg::IDX_W'($urandom_range(cpra_pkg::NUM_PAGES - 1, 0)));
            end
        end
        if ($urandom_range(1) == 1)
            len = cpra_pkg::RUN_W'($urandom_range(8191, 4096));
        else
            len = cpra_pkg::RUN_W'($urandom_range(4095, 600));
        alloc_run(len);
        alloc_run(cpra_pkg::RUN_W'(1));
    endtask

    // response side: check, then pick ready for the next cycle
    initial begin
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                sb.check_response(rsp_ch.status, rsp_ch.run_start);
            // one long hold-off so the block backs up into the request side
            if (!hold_done && sb.n_requests >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct());
            end
        end
    end

    // watchdog on cycles with no transaction anywhere
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
                (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
                (psel === 1'b1 && penable === 1'b1 && pready === 1'b1))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // main sequence
    initial begin
        sb = new();
        i_rst_n           <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.op         <= cpra_pkg::OP_ALLOC;
        req_ch.run_length <= '0;
        req_ch.page_index <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_pool(cpra_pkg::POOL_RESET);

        // empty pool: every release out of range, every nonzero allocation fails
        set_pool('0);
        free_page('0);
        free_page(cpra_pkg::IDX_W'(cpra_pkg::NUM_PAGES - 1));
        alloc_run(cpra_pkg::RUN_W'(1));
        alloc_run('0);
        alloc_run('1);

        // small pool: runs found, already-free page, scan to the pool end
        set_pool(cpra_pkg::POOL_W'(16));
        free_page(cpra_pkg::IDX_W'(2));
        free_page(cpra_pkg::IDX_W'(3));
        free_page(cpra_pkg::IDX_W'(4));
        free_page(cpra_pkg::IDX_W'(5));
        free_page(cpra_pkg::IDX_W'(3));
        free_page(cpra_pkg::IDX_W'(16));
        free_page(cpra_pkg::IDX_W'(cpra_pkg::NUM_PAGES - 1));
        alloc_run('0);
        alloc_run(cpra_pkg::RUN_W'(2));
        alloc_run(cpra_pkg::RUN_W'(1));
        alloc_run(cpra_pkg::RUN_W'(2));
        free_page(cpra_pkg::IDX_W'(10));
        alloc_run(cpra_pkg::RUN_W'(1));

        // pool shrunk below the rover
        set_pool(cpra_pkg::POOL_W'(8));
        alloc_run(cpra_pkg::RUN_W'(1));
        free_page(cpra_pkg::IDX_W'(7));
        free_page(cpra_pkg::IDX_W'(8));
        alloc_run(cpra_pkg::RUN_W'(cpra_pkg::NUM_PAGES));

        // growing pools let the rover move on
        for (int i = 0; i < N_PHASES; i++)
            run_phase(cpra_pkg::POOL_W'(PHASE_POOLS[i]));

        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.n_failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
